// ----- hw/rtl/lifx_pkg.sv -----
// Shared types, register indexes, constants and fixed-point helpers for the
// LIF neuron step unit with exponential synaptic currents. No dependencies.
`default_nettype none

package lifx_pkg;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEMBRANE_DECAY   = 3'd0,
    REG_EXC_DECAY        = 3'd1,
    REG_INH_DECAY        = 3'd2,
    REG_EXC_GAIN         = 3'd3,
    REG_INH_GAIN         = 3'd4,
    REG_DRIVE_GAIN       = 3'd5,
    REG_THRESHOLD_LEVEL  = 3'd6,
    REG_REFRACTORY_TICKS = 3'd7
  } lifx_reg_t;

  localparam logic signed [31:0] BIAS_CURRENT = 32'sd0;
  localparam logic signed [31:0] RESET_LEVEL  = 32'sd0;
  localparam logic signed [25:0] ONE_Q24      = 26'sd16777216;
  localparam logic signed [63:0] HALF_Q24     = 64'sd8388608;

  typedef struct packed {
    logic        [26:0] membrane_decay;
    logic        [24:0] exc_decay;
    logic        [24:0] inh_decay;
    logic        [26:0] exc_gain;
    logic        [26:0] inh_gain;
    logic        [26:0] drive_gain;
    logic signed [31:0] threshold_level;
    logic        [15:0] refractory_ticks;
  } lifx_cfg_t;

  typedef struct packed {
    logic        [30:0] exc_spike_sum;
    logic signed [31:0] inh_spike_sum;
    logic signed [31:0] drive_current;
    logic signed [31:0] filtered_current;
  } lifx_item_t;

  typedef struct packed {
    logic signed [31:0] membrane;
    logic signed [31:0] exc_current;
    logic signed [31:0] inh_current;
    logic signed [31:0] held_drive;
    logic signed [31:0] held_filtered;
    logic        [15:0] refractory_left;
  } lifx_state_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] membrane_level;
    logic signed [31:0] exc_current_out;
    logic signed [31:0] inh_current_out;
    logic               in_refractory;
  } lifx_result_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Rounds half up from Q24 scale, then saturates to 32 bits.
  function automatic logic signed [31:0] rs24(input logic signed [63:0] acc);
    logic signed [63:0] x;
    logic signed [39:0] q;
    x = acc + HALF_Q24;
    q = x[63:24];
    return sat32(41'(q));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lifx_cfg_regs.sv -----
// Configuration register file of the LIF neuron step unit.
// Depends on lifx_pkg for the register indexes and the configuration struct.
`default_nettype none

module lifx_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lifx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output lifx_pkg::lifx_cfg_t                    cfg
);

  lifx_pkg::lifx_cfg_t cfg_r;
  lifx_pkg::lifx_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        lifx_pkg::REG_MEMBRANE_DECAY:   cfg_nxt.membrane_decay   = cfg_data[26:0];
        lifx_pkg::REG_EXC_DECAY:        cfg_nxt.exc_decay        = cfg_data[24:0];
        lifx_pkg::REG_INH_DECAY:        cfg_nxt.inh_decay        = cfg_data[24:0];
        lifx_pkg::REG_EXC_GAIN:         cfg_nxt.exc_gain         = cfg_data[26:0];
        lifx_pkg::REG_INH_GAIN:         cfg_nxt.inh_gain         = cfg_data[26:0];
        lifx_pkg::REG_DRIVE_GAIN:       cfg_nxt.drive_gain       = cfg_data[26:0];
        lifx_pkg::REG_THRESHOLD_LEVEL:  cfg_nxt.threshold_level  = $signed(cfg_data);
        lifx_pkg::REG_REFRACTORY_TICKS: cfg_nxt.refractory_ticks = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.membrane_decay   <= 27'd16610283;
      cfg_r.exc_decay        <= 25'd15958970;
      cfg_r.inh_decay        <= 25'd15958970;
      cfg_r.exc_gain         <= 27'd6513;
      cfg_r.inh_gain         <= 27'd6513;
      cfg_r.drive_gain       <= 27'd6677;
      cfg_r.threshold_level  <= 32'sd983040;
      cfg_r.refractory_ticks <= 16'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lifx_tick.sv -----
// Combinational update of the neuron state for one tick: membrane propagation,
// synaptic current decay, threshold test and refractory handling. Uses lifx_pkg.
`default_nettype none

module lifx_tick (
  input  wire lifx_pkg::lifx_cfg_t    cfg,
  input  wire lifx_pkg::lifx_state_t  st,
  input  wire lifx_pkg::lifx_item_t   item,
  output lifx_pkg::lifx_state_t       st_nxt,
  output lifx_pkg::lifx_result_t      res
);

  logic signed [27:0] mem_coef;
  logic signed [27:0] exc_gain_coef;
  logic signed [27:0] inh_gain_coef;
  logic signed [27:0] drive_coef;
  logic signed [25:0] exc_decay_coef;
  logic signed [25:0] inh_decay_coef;
  logic signed [25:0] filt_coef;
  logic signed [32:0] drive_sum;

  logic signed [59:0] p_mem;
  logic signed [59:0] p_exc_gain;
  logic signed [59:0] p_inh_gain;
  logic signed [60:0] p_drive;
  logic signed [57:0] p_exc_decay;
  logic signed [57:0] p_filt;
  logic signed [57:0] p_inh_decay;

  logic signed [63:0] acc_mem;
  logic signed [63:0] acc_exc;
  logic signed [63:0] acc_inh;
  logic signed [40:0] exc_sum;
  logic signed [40:0] inh_sum;
  logic signed [31:0] mem_int;
  logic signed [31:0] mem_step;
  logic        [15:0] refr_step;
  logic               fire;

  assign mem_coef       = $signed({1'b0, cfg.membrane_decay});
  assign exc_gain_coef  = $signed({1'b0, cfg.exc_gain});
  assign inh_gain_coef  = $signed({1'b0, cfg.inh_gain});
  assign drive_coef     = $signed({1'b0, cfg.drive_gain});
  assign exc_decay_coef = $signed({1'b0, cfg.exc_decay});
  assign inh_decay_coef = $signed({1'b0, cfg.inh_decay});
  assign filt_coef      = lifx_pkg::ONE_Q24 - exc_decay_coef;
  assign drive_sum      = 33'(lifx_pkg::BIAS_CURRENT) + 33'(st.held_drive);

  assign p_mem       = st.membrane * mem_coef;
  assign p_exc_gain  = st.exc_current * exc_gain_coef;
  assign p_inh_gain  = st.inh_current * inh_gain_coef;
  assign p_drive     = drive_sum * drive_coef;
  assign p_exc_decay = st.exc_current * exc_decay_coef;
  assign p_filt      = st.held_filtered * filt_coef;
  assign p_inh_decay = st.inh_current * inh_decay_coef;

  assign acc_mem = 64'(p_mem) + 64'(p_exc_gain) + 64'(p_inh_gain) + 64'(p_drive);
  assign acc_exc = 64'(p_exc_decay) + 64'(p_filt);
  assign acc_inh = 64'(p_inh_decay);

  assign mem_int = lifx_pkg::rs24(acc_mem);
  assign exc_sum = 41'(lifx_pkg::rs24(acc_exc)) + 41'($signed({1'b0, item.exc_spike_sum}));
  assign inh_sum = 41'(lifx_pkg::rs24(acc_inh)) + 41'(item.inh_spike_sum);

  always_comb begin
    if (st.refractory_left == 16'd0) begin
      mem_step  = mem_int;
      refr_step = st.refractory_left;
    end else begin
      mem_step  = st.membrane;
      refr_step = st.refractory_left - 16'd1;
    end
  end

  assign fire = (mem_step >= cfg.threshold_level);

  always_comb begin
    st_nxt.membrane        = fire ? lifx_pkg::RESET_LEVEL : mem_step;
    st_nxt.refractory_left = fire ? cfg.refractory_ticks : refr_step;
    st_nxt.exc_current     = lifx_pkg::sat32(exc_sum);
    st_nxt.inh_current     = lifx_pkg::sat32(inh_sum);
    st_nxt.held_drive      = item.drive_current;
    st_nxt.held_filtered   = item.filtered_current;
  end

  always_comb begin
    res.spike           = fire;
    res.membrane_level  = st_nxt.membrane;
    res.exc_current_out = st_nxt.exc_current;
    res.inh_current_out = st_nxt.inh_current;
    res.in_refractory   = (st_nxt.refractory_left != 16'd0);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lif_exp_synapse_neuron_step_unit.sv -----
// Top level of the LIF neuron step unit with exponential synaptic currents.
// Depends on lifx_pkg, lifx_cfg_regs and lifx_tick.
//
//   channel | direction | handshake              | payload
//   in_     | request   | in_valid / in_ready    | spike sums, drive and filtered current
//   out_    | result    | out_valid / out_ready  | spike, membrane, currents, refractory flag
//   cfg_    | write     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle is sustained while out_ready is held high; the state update
// for a tick is combinational between the input register and the result register, so
// a request is held in the input register and its result in the result register.
// The tick update depends on the state left by the previous tick, which closes the
// loop through the seven parallel multipliers of the tick logic.
// Reset clears the neuron state and loads the default coefficients.
// A stalled result register holds the next request in the input register.
`default_nettype none

module lif_exp_synapse_neuron_step_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [30:0]                      in_exc_spike_sum,
  input  wire logic signed [31:0]               in_inh_spike_sum,
  input  wire logic signed [31:0]               in_drive_current,
  input  wire logic signed [31:0]               in_filtered_current,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_spike,
  output logic signed [31:0]                    out_membrane_level,
  output logic signed [31:0]                    out_exc_current_out,
  output logic signed [31:0]                    out_inh_current_out,
  output logic                                  out_in_refractory,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lifx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  lifx_pkg::lifx_cfg_t    cfg;
  lifx_pkg::lifx_item_t   s1_item_r;
  lifx_pkg::lifx_state_t  st_r;
  lifx_pkg::lifx_state_t  st_nxt;
  lifx_pkg::lifx_result_t res_nxt;
  lifx_pkg::lifx_result_t out_res_r;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   adv;
  logic                   in_acc;

  lifx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lifx_tick u_tick (
    .cfg    (cfg),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign adv           = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || adv;
  assign in_acc        = in_valid && in_ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.exc_spike_sum    <= in_exc_spike_sum;
      s1_item_r.inh_spike_sum    <= in_inh_spike_sum;
      s1_item_r.drive_current    <= in_drive_current;
      s1_item_r.filtered_current <= in_filtered_current;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_spike           = out_res_r.spike;
  assign out_membrane_level  = out_res_r.membrane_level;
  assign out_exc_current_out = out_res_r.exc_current_out;
  assign out_inh_current_out = out_res_r.inh_current_out;
  assign out_in_refractory   = out_res_r.in_refractory;

  a_spike_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.spike |-> out_res_r.membrane_level == lifx_pkg::RESET_LEVEL)
    else $error("spike result without membrane reset");

  a_refr_flag: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_res_r.in_refractory == (st_r.refractory_left != 16'd0))
    else $error("refractory flag disagrees with refractory count");

  a_refr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (st_r.refractory_left != 16'd0) && !res_nxt.spike
    |=> st_r.membrane == $past(st_r.membrane))
    else $error("membrane moved during refractory period");

  a_refr_count: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !res_nxt.spike |=> st_r.refractory_left <= $past(st_r.refractory_left))
    else $error("refractory count grew without a spike");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled while the pipeline could move");

endmodule

`default_nettype wire
